// ===== sv/lfk_pkg.sv =====
// Shared constants, register codes and series tables for the leg forward kinematics block.
package lfk_pkg;

   localparam int IN_ANGLE_WIDTH = 16;
   localparam int LINK_WIDTH     = 12;
   localparam int ROOT_WIDTH     = 15;
   localparam int LOCAL_WIDTH    = 15;
   localparam int WORLD_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 15;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROOT_LINK_LENGTH  = 3'd0,
      REG_UPPER_LINK_LENGTH = 3'd1,
      REG_LOWER_LINK_LENGTH = 3'd2,
      REG_FOOT_LINK_LENGTH  = 3'd3,
      REG_ROOT_X            = 3'd4,
      REG_ROOT_Y            = 3'd5,
      REG_ROOT_Z            = 3'd6
   } cfg_index_type;

   localparam int ANGLE_WIDTH  = 18;
   localparam int QUARTER_TURN = 9000;
   localparam int HALF_TURN    = 18000;
   localparam int ANGLE_BIAS   = 108000;
   localparam int QUOT_WIDTH   = 5;
   localparam int REM_WIDTH    = 14;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [17:0] PI_QUOT = 18'(64'(PI_Q30) / 64'(HALF_TURN));
   localparam logic [12:0] PI_REM  = 13'(64'(PI_Q30) - 64'(PI_QUOT) * 64'(HALF_TURN));

   localparam int QUARTER_SHIFT       = 32;
   localparam int QUARTER_RECIP_WIDTH = 19;
   localparam logic [QUARTER_RECIP_WIDTH-1:0] QUARTER_RECIP =
      QUARTER_RECIP_WIDTH'((64'd1 << QUARTER_SHIFT) / 64'(QUARTER_TURN));

   localparam int NUM_WIDTH         = 26;
   localparam int HALF_SHIFT        = 40;
   localparam int HALF_QUOT_WIDTH   = 12;
   localparam logic [NUM_WIDTH-1:0] HALF_RECIP =
      NUM_WIDTH'((64'd1 << HALF_SHIFT) / 64'(HALF_TURN));

   localparam int THETA_WIDTH = 31;
   localparam int TERM_WIDTH  = 32;
   localparam int ACC_WIDTH   = 34;
   localparam int DIV_WIDTH   = 9;
   localparam logic [TERM_WIDTH-1:0] ONE_Q30 = 32'h4000_0000;

   localparam int SERIES_TERMS = 8;

   localparam logic [DIV_WIDTH-1:0] SIN_DIV [SERIES_TERMS] =
      '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
   localparam logic [DIV_WIDTH-1:0] COS_DIV [SERIES_TERMS] =
      '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

   localparam int SIN_SHIFT [SERIES_TERMS] = '{33, 35, 36, 37, 37, 38, 38, 39};
   localparam int COS_SHIFT [SERIES_TERMS] = '{32, 34, 35, 36, 37, 38, 38, 38};

   localparam logic [TERM_WIDTH-1:0] SIN_RECIP [SERIES_TERMS] = '{
      32'((64'd1 << 33) / 64'd6),   32'((64'd1 << 35) / 64'd20),
      32'((64'd1 << 36) / 64'd42),  32'((64'd1 << 37) / 64'd72),
      32'((64'd1 << 37) / 64'd110), 32'((64'd1 << 38) / 64'd156),
      32'((64'd1 << 38) / 64'd210), 32'((64'd1 << 39) / 64'd272)
   };
   localparam logic [TERM_WIDTH-1:0] COS_RECIP [SERIES_TERMS] = '{
      32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 34) / 64'd12),
      32'((64'd1 << 35) / 64'd30),  32'((64'd1 << 36) / 64'd56),
      32'((64'd1 << 37) / 64'd90),  32'((64'd1 << 38) / 64'd132),
      32'((64'd1 << 38) / 64'd182), 32'((64'd1 << 38) / 64'd240)
   };

   localparam int SINCOS_STAGES = 6 + 3 * SERIES_TERMS + 1;

endpackage

// ===== sv/lfk_if.sv =====
// Request and response channel interfaces of the leg forward kinematics block.
interface lfk_req_if;
   logic valid;
   logic ready;
   logic signed [lfk_pkg::IN_ANGLE_WIDTH-1:0] angle_root;
   logic signed [lfk_pkg::IN_ANGLE_WIDTH-1:0] angle_middle;
   logic signed [lfk_pkg::IN_ANGLE_WIDTH-1:0] angle_end;

   modport source (output valid, angle_root, angle_middle, angle_end, input ready);
   modport sink (input valid, angle_root, angle_middle, angle_end, output ready);
endinterface

interface lfk_rsp_if;
   logic valid;
   logic ready;
   logic signed [lfk_pkg::LOCAL_WIDTH-1:0] local_x;
   logic signed [lfk_pkg::LOCAL_WIDTH-1:0] local_y;
   logic signed [lfk_pkg::WORLD_WIDTH-1:0] world_x;
   logic signed [lfk_pkg::WORLD_WIDTH-1:0] world_y;
   logic signed [lfk_pkg::ROOT_WIDTH-1:0]  world_z;

   modport source (output valid, local_x, local_y, world_x, world_y, world_z, input ready);
   modport sink (input valid, local_x, local_y, world_x, world_y, world_z, output ready);
endinterface

// ===== sv/lfk_sincos.sv =====
// Pipelined fixed-point sine and cosine of one biased cumulative joint angle.
module lfk_sincos #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic [lfk_pkg::SINCOS_STAGES-1:0]      load,
   input  logic [lfk_pkg::ANGLE_WIDTH-1:0]        angle,
   output logic signed [FRAC_BITS+1:0]            sin_out,
   output logic signed [FRAC_BITS+1:0]            cos_out
);

   localparam int AW  = lfk_pkg::ANGLE_WIDTH;
   localparam int QPW = AW + lfk_pkg::QUARTER_RECIP_WIDTH;
   localparam int RW  = lfk_pkg::REM_WIDTH;
   localparam int NW  = lfk_pkg::NUM_WIDTH;
   localparam int HPW = 2 * NW;
   localparam int TW  = lfk_pkg::THETA_WIDTH;
   localparam int MW  = lfk_pkg::TERM_WIDTH;
   localparam int CW  = lfk_pkg::ACC_WIDTH;
   localparam int NT  = lfk_pkg::SERIES_TERMS;
   localparam int RND = 30 - FRAC_BITS;
   localparam int FW  = FRAC_BITS + 1;
   localparam int LAST = lfk_pkg::SINCOS_STAGES - 1;

   // quotient by a quarter turn
   logic [AW-1:0]  u0_ff;
   logic [QPW-1:0] qprod0_ff;
   logic [QPW-1:0] qprod0_in;

   assign qprod0_in = QPW'(angle) * QPW'(lfk_pkg::QUARTER_RECIP);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         u0_ff     <= angle;
         qprod0_ff <= qprod0_in;
      end
   end

   // quadrant and remainder
   logic [lfk_pkg::QUOT_WIDTH-1:0] qhat;
   logic [AW-1:0] qrem;
   logic [1:0]    quad1_ff, quad1_in;
   logic [RW-1:0] rem1_ff, rem1_in;

   always_comb begin
      qhat = qprod0_ff[lfk_pkg::QUARTER_SHIFT +: lfk_pkg::QUOT_WIDTH];
      qrem = u0_ff - AW'(AW'(qhat) * AW'(lfk_pkg::QUARTER_TURN));
      if (qrem >= AW'(lfk_pkg::QUARTER_TURN)) begin
         quad1_in = qhat[1:0] + 2'd1;
         rem1_in  = RW'(qrem - AW'(lfk_pkg::QUARTER_TURN));
      end else begin
         quad1_in = qhat[1:0];
         rem1_in  = RW'(qrem);
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         quad1_ff <= quad1_in;
         rem1_ff  <= rem1_in;
      end
   end

   // fractional part of the angle-to-radian scaling
   logic [NW-1:0] n2_ff, n2_in;
   logic [RW-1:0] rem2_ff;
   logic [1:0]    quad2_ff;

   assign n2_in = NW'(rem1_ff) * NW'(lfk_pkg::PI_REM) + NW'(lfk_pkg::HALF_TURN / 2);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         n2_ff    <= n2_in;
         rem2_ff  <= rem1_ff;
         quad2_ff <= quad1_ff;
      end
   end

   logic [HPW-1:0] hprod3_ff, hprod3_in;
   logic [NW-1:0]  n3_ff;
   logic [TW-1:0]  rq3_ff, rq3_in;
   logic [1:0]     quad3_ff;

   assign hprod3_in = HPW'(n2_ff) * HPW'(lfk_pkg::HALF_RECIP);
   assign rq3_in    = TW'(32'(rem2_ff) * 32'(lfk_pkg::PI_QUOT));

   always_ff @(posedge clock) begin
      if (load[3]) begin
         hprod3_ff <= hprod3_in;
         n3_ff     <= n2_ff;
         rq3_ff    <= rq3_in;
         quad3_ff  <= quad2_ff;
      end
   end

   logic [lfk_pkg::HALF_QUOT_WIDTH-1:0] hq;
   logic [NW-1:0] hrem;
   logic [TW-1:0] theta4_ff, theta4_in;
   logic [1:0]    quad4_ff;

   always_comb begin
      hq   = hprod3_ff[lfk_pkg::HALF_SHIFT +: lfk_pkg::HALF_QUOT_WIDTH];
      hrem = n3_ff - NW'(NW'(hq) * NW'(lfk_pkg::HALF_TURN));
      theta4_in = rq3_ff + TW'(hq) + ((hrem >= NW'(lfk_pkg::HALF_TURN)) ? TW'(1) : TW'(0));
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         theta4_ff <= theta4_in;
         quad4_ff  <= quad3_ff;
      end
   end

   logic [MW-1:0] x2_5_ff, x2_5_in;
   logic [TW-1:0] theta5_ff;
   logic [1:0]    quad5_ff;

   assign x2_5_in = MW'((64'(theta4_ff) * 64'(theta4_ff) + (64'd1 << 29)) >> 30);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         x2_5_ff   <= x2_5_in;
         theta5_ff <= theta4_ff;
         quad5_ff  <= quad4_ff;
      end
   end

   // series terms
   logic [MW-1:0]        ts_q [NT+1];
   logic [MW-1:0]        tc_q [NT+1];
   logic [MW-1:0]        x2_q [NT+1];
   logic signed [CW-1:0] ss_q [NT+1];
   logic signed [CW-1:0] sc_q [NT+1];
   logic [1:0]           quad_q [NT+1];

   assign ts_q[0]   = MW'(theta5_ff);
   assign tc_q[0]   = lfk_pkg::ONE_Q30;
   assign x2_q[0]   = x2_5_ff;
   assign ss_q[0]   = $signed(CW'(theta5_ff));
   assign sc_q[0]   = $signed(CW'(lfk_pkg::ONE_Q30));
   assign quad_q[0] = quad5_ff;

   for (genvar k = 0; k < NT; k++) begin : g_term
      localparam int  JA = 6 + 3 * k;
      localparam bit  SUBTRACT = (k % 2) == 0;

      logic [MW-1:0]        vs_a_ff, vc_a_ff, x2_a_ff;
      logic [MW-1:0]        vs_a_in, vc_a_in;
      logic signed [CW-1:0] ss_a_ff, sc_a_ff;
      logic [1:0]           quad_a_ff;

      logic [2*MW-1:0]      ms_b_ff, mc_b_ff, ms_b_in, mc_b_in;
      logic [MW-1:0]        vs_b_ff, vc_b_ff, x2_b_ff;
      logic signed [CW-1:0] ss_b_ff, sc_b_ff;
      logic [1:0]           quad_b_ff;

      logic [MW-1:0]        qs, qc, rs, rc;
      logic [MW-1:0]        ts_c_ff, tc_c_ff, x2_c_ff, ts_c_in, tc_c_in;
      logic signed [CW-1:0] ss_c_ff, sc_c_ff, ss_c_in, sc_c_in;
      logic [1:0]           quad_c_ff;

      assign vs_a_in = MW'((64'(ts_q[k]) * 64'(x2_q[k])) >> 30);
      assign vc_a_in = MW'((64'(tc_q[k]) * 64'(x2_q[k])) >> 30);

      always_ff @(posedge clock) begin
         if (load[JA]) begin
            vs_a_ff   <= vs_a_in;
            vc_a_ff   <= vc_a_in;
            x2_a_ff   <= x2_q[k];
            ss_a_ff   <= ss_q[k];
            sc_a_ff   <= sc_q[k];
            quad_a_ff <= quad_q[k];
         end
      end

      assign ms_b_in = 64'(vs_a_ff) * 64'(lfk_pkg::SIN_RECIP[k]);
      assign mc_b_in = 64'(vc_a_ff) * 64'(lfk_pkg::COS_RECIP[k]);

      always_ff @(posedge clock) begin
         if (load[JA+1]) begin
            ms_b_ff   <= ms_b_in;
            mc_b_ff   <= mc_b_in;
            vs_b_ff   <= vs_a_ff;
            vc_b_ff   <= vc_a_ff;
            x2_b_ff   <= x2_a_ff;
            ss_b_ff   <= ss_a_ff;
            sc_b_ff   <= sc_a_ff;
            quad_b_ff <= quad_a_ff;
         end
      end

      always_comb begin
         qs = MW'(ms_b_ff >> lfk_pkg::SIN_SHIFT[k]);
         qc = MW'(mc_b_ff >> lfk_pkg::COS_SHIFT[k]);
         rs = vs_b_ff - MW'(64'(qs) * 64'(lfk_pkg::SIN_DIV[k]));
         rc = vc_b_ff - MW'(64'(qc) * 64'(lfk_pkg::COS_DIV[k]));
         ts_c_in = qs + ((rs >= MW'(lfk_pkg::SIN_DIV[k])) ? MW'(1) : MW'(0));
         tc_c_in = qc + ((rc >= MW'(lfk_pkg::COS_DIV[k])) ? MW'(1) : MW'(0));
         if (SUBTRACT) begin
            ss_c_in = ss_b_ff - $signed(CW'(ts_c_in));
            sc_c_in = sc_b_ff - $signed(CW'(tc_c_in));
         end else begin
            ss_c_in = ss_b_ff + $signed(CW'(ts_c_in));
            sc_c_in = sc_b_ff + $signed(CW'(tc_c_in));
         end
      end

      always_ff @(posedge clock) begin
         if (load[JA+2]) begin
            ts_c_ff   <= ts_c_in;
            tc_c_ff   <= tc_c_in;
            x2_c_ff   <= x2_b_ff;
            ss_c_ff   <= ss_c_in;
            sc_c_ff   <= sc_c_in;
            quad_c_ff <= quad_b_ff;
         end
      end

      assign ts_q[k+1]   = ts_c_ff;
      assign tc_q[k+1]   = tc_c_ff;
      assign x2_q[k+1]   = x2_c_ff;
      assign ss_q[k+1]   = ss_c_ff;
      assign sc_q[k+1]   = sc_c_ff;
      assign quad_q[k+1] = quad_c_ff;
   end

   // clamp, round and unfold the quadrant
   logic [TW-1:0] s_clamp, c_clamp;
   logic [FW-1:0] s_frac, c_frac;
   logic signed [FRAC_BITS+1:0] s_pos, c_pos;
   logic signed [FRAC_BITS+1:0] sin_ff, cos_ff, sin_in, cos_in;

   always_comb begin
      if (ss_q[NT][CW-1]) begin
         s_clamp = '0;
      end else if (ss_q[NT] > $signed(CW'(lfk_pkg::ONE_Q30))) begin
         s_clamp = TW'(lfk_pkg::ONE_Q30);
      end else begin
         s_clamp = TW'(ss_q[NT]);
      end
      if (sc_q[NT][CW-1]) begin
         c_clamp = '0;
      end else if (sc_q[NT] > $signed(CW'(lfk_pkg::ONE_Q30))) begin
         c_clamp = TW'(lfk_pkg::ONE_Q30);
      end else begin
         c_clamp = TW'(sc_q[NT]);
      end
      s_frac = FW'((s_clamp + (TW'(1) << (RND - 1))) >> RND);
      c_frac = FW'((c_clamp + (TW'(1) << (RND - 1))) >> RND);
      s_pos  = $signed({1'b0, s_frac});
      c_pos  = $signed({1'b0, c_frac});
      case (quad_q[NT])
         2'd0: begin
            sin_in = s_pos;
            cos_in = c_pos;
         end
         2'd1: begin
            sin_in = c_pos;
            cos_in = -s_pos;
         end
         2'd2: begin
            sin_in = -s_pos;
            cos_in = -c_pos;
         end
         default: begin
            sin_in = -c_pos;
            cos_in = s_pos;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[LAST]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== sv/leg_forward_kinematics.sv =====
// Top level of the leg forward kinematics block: registers, angle sums, position pipeline.
//
// A request on req_chan carries three joint angles in hundredths of a degree. The
// block returns one response on rsp_chan per request, in order: the tip position
// relative to the leg root (local_x, local_y) and in the world frame (world_x,
// world_y saturated to 16 bits, world_z equal to the root z), in 0.1 mm units.
// Link lengths and the root position are written through the csr_ port; the user must
// write them only while no request is in flight, which the block itself does not enforce.
// An accepted request passes the angle-sum, sine/cosine, product, local and output
// registers to rsp_chan. One request is accepted every cycle while ready is not held
// off; the 35-stage pipeline runs three sine/cosine lanes (8-term series, three stages per term).
// Every stage keeps a valid bit. When the receiver holds off ready, the oldest
// response stays in the output register and the stages behind it keep filling
// empty slots, so requests are still taken until all 35 stages are full.
// Reset clears all valid bits and the configuration registers to zero.
module leg_forward_kinematics #(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lfk_req_if.sink                               req_chan,
   lfk_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [lfk_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lfk_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int SC       = lfk_pkg::SINCOS_STAGES;
   localparam int ST_PROD  = SC + 1;
   localparam int ST_LOCAL = SC + 2;
   localparam int ST_OUT   = SC + 3;
   localparam int STAGES   = SC + 4;
   localparam int AW       = lfk_pkg::ANGLE_WIDTH;
   localparam int TRIG_W   = TRIG_FRACTION_BITS + 2;
   localparam int LEN_W    = 14;
   localparam int PROD_W   = TRIG_W + LEN_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int RND_W    = SUM_W - TRIG_FRACTION_BITS;
   localparam int LW       = lfk_pkg::LOCAL_WIDTH;
   localparam int WW       = lfk_pkg::WORLD_WIDTH;
   localparam int RW       = lfk_pkg::ROOT_WIDTH;

   // configuration registers
   logic [lfk_pkg::LINK_WIDTH-1:0] root_link_ff, upper_link_ff, lower_link_ff, foot_link_ff;
   logic signed [RW-1:0] root_x_ff, root_y_ff, root_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_link_ff  <= '0;
         upper_link_ff <= '0;
         lower_link_ff <= '0;
         foot_link_ff  <= '0;
         root_x_ff     <= '0;
         root_y_ff     <= '0;
         root_z_ff     <= '0;
      end else if (csr_we) begin
         unique case (lfk_pkg::cfg_index_type'(csr_index))
            lfk_pkg::REG_ROOT_LINK_LENGTH:  root_link_ff  <= csr_wdata[lfk_pkg::LINK_WIDTH-1:0];
            lfk_pkg::REG_UPPER_LINK_LENGTH: upper_link_ff <= csr_wdata[lfk_pkg::LINK_WIDTH-1:0];
            lfk_pkg::REG_LOWER_LINK_LENGTH: lower_link_ff <= csr_wdata[lfk_pkg::LINK_WIDTH-1:0];
            lfk_pkg::REG_FOOT_LINK_LENGTH:  foot_link_ff  <= csr_wdata[lfk_pkg::LINK_WIDTH-1:0];
            lfk_pkg::REG_ROOT_X:            root_x_ff     <= $signed(csr_wdata[RW-1:0]);
            lfk_pkg::REG_ROOT_Y:            root_y_ff     <= $signed(csr_wdata[RW-1:0]);
            lfk_pkg::REG_ROOT_Z:            root_z_ff     <= $signed(csr_wdata[RW-1:0]);
            default: begin
            end
         endcase
      end
   end

   // stage occupancy and stall chain
   logic [STAGES-1:0] valid_ff, valid_in, load;
   logic [STAGES:0]   hold;

   assign hold[STAGES] = !rsp_chan.ready;
   for (genvar i = 0; i < STAGES; i++) begin : g_hold
      assign hold[i] = valid_ff[i] && hold[i+1];
   end
   assign load     = ~hold[STAGES-1:0];
   assign valid_in = {valid_ff[STAGES-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_chan.ready = load[0];

   // cumulative angles, biased to stay positive
   logic signed [AW:0] t1, t2, t3;
   logic [AW-1:0] u1_ff, u2_ff, u3_ff;

   always_comb begin
      t1 = (AW+1)'(req_chan.angle_root);
      t2 = t1 + (AW+1)'(req_chan.angle_middle);
      t3 = t2 + (AW+1)'(req_chan.angle_end);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         u1_ff <= AW'(t1 + (AW+1)'(lfk_pkg::ANGLE_BIAS));
         u2_ff <= AW'(t2 + (AW+1)'(lfk_pkg::ANGLE_BIAS));
         u3_ff <= AW'(t3 + (AW+1)'(lfk_pkg::ANGLE_BIAS));
      end
   end

   logic signed [TRIG_W-1:0] sin1, cos1, sin2, cos2, sin3, cos3;

   lfk_sincos #(.FRAC_BITS(TRIG_FRACTION_BITS)) u_sincos1 (
      .clock   (clock),
      .load    (load[SC:1]),
      .angle   (u1_ff),
      .sin_out (sin1),
      .cos_out (cos1)
   );

   lfk_sincos #(.FRAC_BITS(TRIG_FRACTION_BITS)) u_sincos2 (
      .clock   (clock),
      .load    (load[SC:1]),
      .angle   (u2_ff),
      .sin_out (sin2),
      .cos_out (cos2)
   );

   lfk_sincos #(.FRAC_BITS(TRIG_FRACTION_BITS)) u_sincos3 (
      .clock   (clock),
      .load    (load[SC:1]),
      .angle   (u3_ff),
      .sin_out (sin3),
      .cos_out (cos3)
   );

   // link length times sine and cosine
   logic signed [LEN_W-1:0] len1, len2, len34;
   logic signed [PROD_W-1:0] px1_ff, px2_ff, px3_ff, py1_ff, py2_ff, py3_ff;

   always_comb begin
      len1  = $signed(LEN_W'(root_link_ff));
      len2  = $signed(LEN_W'(upper_link_ff));
      len34 = $signed(LEN_W'(LEN_W'(lower_link_ff) + LEN_W'(foot_link_ff)));
   end

   always_ff @(posedge clock) begin
      if (load[ST_PROD]) begin
         px1_ff <= PROD_W'(len1) * PROD_W'(cos1);
         px2_ff <= PROD_W'(len2) * PROD_W'(cos2);
         px3_ff <= PROD_W'(len34) * PROD_W'(cos3);
         py1_ff <= PROD_W'(len1) * PROD_W'(sin1);
         py2_ff <= PROD_W'(len2) * PROD_W'(sin2);
         py3_ff <= PROD_W'(len34) * PROD_W'(sin3);
      end
   end

   function automatic logic signed [LW-1:0] round_local(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0]        mag;
      logic [RND_W-1:0]        rnd;
      logic signed [RND_W:0]   val;
      logic signed [LW-1:0]    res;
      mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      rnd = RND_W'((mag + (SUM_W'(1) << (TRIG_FRACTION_BITS - 1))) >> TRIG_FRACTION_BITS);
      val = s[SUM_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
      if (val > $signed((RND_W+1)'(2 ** (LW - 1) - 1))) begin
         res = $signed(LW'(2 ** (LW - 1) - 1));
      end else if (val < -$signed((RND_W+1)'(2 ** (LW - 1)))) begin
         res = $signed(LW'(2 ** (LW - 1)));
      end else begin
         res = LW'(val);
      end
      return res;
   endfunction

   function automatic logic signed [WW-1:0] sat_world(input logic signed [LW-1:0] l,
                                                      input logic signed [RW-1:0] r);
      logic signed [WW:0] sum;
      logic signed [WW-1:0] res;
      sum = (WW+1)'(l) + (WW+1)'(r);
      if (sum > $signed((WW+1)'(2 ** (WW - 1) - 1))) begin
         res = $signed(WW'(2 ** (WW - 1) - 1));
      end else if (sum < -$signed((WW+1)'(2 ** (WW - 1)))) begin
         res = $signed(WW'(2 ** (WW - 1)));
      end else begin
         res = WW'(sum);
      end
      return res;
   endfunction

   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [LW-1:0] local_x_ff, local_y_ff;

   always_comb begin
      sum_x = SUM_W'(px1_ff) + SUM_W'(px2_ff) + SUM_W'(px3_ff);
      sum_y = SUM_W'(py1_ff) + SUM_W'(py2_ff) + SUM_W'(py3_ff);
   end

   always_ff @(posedge clock) begin
      if (load[ST_LOCAL]) begin
         local_x_ff <= round_local(sum_x);
         local_y_ff <= round_local(sum_y);
      end
   end

   // output register
   logic signed [LW-1:0] out_local_x_ff, out_local_y_ff;
   logic signed [WW-1:0] out_world_x_ff, out_world_y_ff;
   logic signed [RW-1:0] out_world_z_ff;

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         out_local_x_ff <= local_x_ff;
         out_local_y_ff <= local_y_ff;
         out_world_x_ff <= sat_world(local_x_ff, root_x_ff);
         out_world_y_ff <= sat_world(local_y_ff, root_y_ff);
         out_world_z_ff <= root_z_ff;
      end
   end

   assign rsp_chan.valid   = valid_ff[ST_OUT];
   assign rsp_chan.local_x = out_local_x_ff;
   assign rsp_chan.local_y = out_local_y_ff;
   assign rsp_chan.world_x = out_world_x_ff;
   assign rsp_chan.world_y = out_world_y_ff;
   assign rsp_chan.world_z = out_world_z_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the pipeline is full and stalled");

   a_local_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_OUT] |-> (out_local_x_ff >= -15'sd16380 && out_local_x_ff <= 15'sd16380 &&
                            out_local_y_ff >= -15'sd16380 && out_local_y_ff <= 15'sd16380))
      else $error("local position beyond the reach of the leg");

endmodule
